@@ hw/rtl/oda_pkg.sv @@
package oda_pkg;

  localparam int MEM_WORDS_DEF   = 256;
  localparam int MAP_ENTRIES_DEF = 8;
  localparam int REG_COUNT       = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int MAP_W           = 25;
  localparam int CNT_W           = 9;
  // Eight counts of up to 511 plus a subindex of up to 255.
  localparam int SUM_W           = 13;
  localparam int JOB_ADDR_W      = 16;

  localparam logic OP_GET   = 1'b0;
  localparam logic OP_SET   = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] obj_index;
    logic [7:0]  sub_index;
    logic [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] read_value;
    logic [7:0]  word_address;
  } out_t;

  typedef struct packed {
    logic                  op;
    logic                  ok;
    logic [JOB_ADDR_W-1:0] addr;
    logic [31:0]           wdata;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ hw/rtl/oda_ram.sv @@
module oda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/oda_front.sv @@
module oda_front #(
  parameter int MEM_WORDS   = oda_pkg::MEM_WORDS_DEF,
  parameter int MAP_ENTRIES = oda_pkg::MAP_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [oda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oda_pkg::MAP_W-1:0]      cfg_data,
  input  oda_pkg::in_t                   req,
  output oda_pkg::job_t                  job
);

  logic [oda_pkg::MAP_W-1:0] map_r [oda_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < oda_pkg::REG_COUNT; i++) begin
        map_r[i] <= '0;
      end
    end else if (cfg_we) begin
      map_r[cfg_index] <= cfg_data;
    end
  end

  logic                      found;
  logic                      hit;
  logic [oda_pkg::SUM_W-1:0] base;
  logic [oda_pkg::SUM_W-1:0] sum;

  // Walk the map in order; stop at the first index match.
  always_comb begin
    found = 1'b0;
    hit   = 1'b0;
    base  = '0;
    sum   = '0;
    for (int e = 0; e < MAP_ENTRIES; e++) begin
      if (!found) begin
        if (map_r[e][15:0] == req.obj_index) begin
          found = 1'b1;
          sum   = base + oda_pkg::SUM_W'(req.sub_index);
          hit   = ({1'b0, req.sub_index} < map_r[e][24:16]) &&
                  (17'(sum) < 17'(MEM_WORDS));
        end else begin
          base = base + oda_pkg::SUM_W'(map_r[e][24:16]);
        end
      end
    end
  end

  always_comb begin
    job.op    = req.opcode;
    job.ok    = hit;
    job.addr  = hit ? oda_pkg::JOB_ADDR_W'(sum) : '0;
    job.wdata = req.write_value;
  end

endmodule

@@ hw/rtl/oda_queue.sv @@
module oda_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  oda_pkg::job_t push_job,
  input  logic          pop,
  output logic          nonempty,
  output logic          full,
  output oda_pkg::job_t head
);

  oda_pkg::job_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign nonempty = (count_r != 2'd0);
  assign full     = (count_r == 2'd2);
  assign head     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/oda_back.sv @@
module oda_back #(
  parameter int MEM_WORDS = oda_pkg::MEM_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  oda_pkg::job_t       job,
  output logic                job_pop,
  output oda_pkg::back_stat_t stat,
  output logic                res_strobe,
  output oda_pkg::out_t       res
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic          clear_r, clear_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          vld_r;
  logic          rd_en_r;
  logic          st_r;
  logic [7:0]    wa_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  assign job_pop = job_valid && !clear_r;

  always_comb begin
    ram_we    = clear_r || (job_pop && job.ok && (job.op == oda_pkg::OP_SET));
    ram_addr  = clear_r ? clr_addr_r : job.addr[AW-1:0];
    ram_wdata = clear_r ? 32'd0 : job.wdata;
  end

  oda_ram #(
    .WIDTH (32),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sweep zeros through the data memory once after reset.
  always_comb begin
    clr_addr_nxt = clr_addr_r + AW'(1);
    clear_nxt    = clear_r && (clr_addr_r != AW'(MEM_WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
      vld_r      <= 1'b0;
    end else begin
      clear_r    <= clear_nxt;
      if (clear_r) begin
        clr_addr_r <= clr_addr_nxt;
      end
      vld_r      <= job_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      rd_en_r <= job.ok && (job.op == oda_pkg::OP_GET);
      st_r    <= job.ok ? oda_pkg::ST_OK : oda_pkg::ST_RANGE;
      wa_r    <= job.addr[7:0];
    end
  end

  assign stat.clearing = clear_r;

  assign res_strobe       = vld_r;
  assign res.status       = st_r;
  assign res.read_value   = rd_en_r ? ram_rdata : 32'd0;
  assign res.word_address = wa_r;

endmodule

@@ hw/rtl/object_dictionary_access.sv @@
// Object dictionary access. Raise start with a request on in_req while busy
// is low; the result appears on out_result with out_strobe high for exactly
// one cycle, once the job has passed the queue slot and the registered read
// stage. Results cannot be held off, so capture them on the strobe. A
// request is taken every cycle while busy is low: the map scan resolves the
// address in the cycle of acceptance, and a two-entry queue hands it to the
// data memory port, whose read is registered. After reset busy stays high
// while the data memory is cleared one word per cycle; map writes on cfg_*
// are taken at any time (cfg_ready is always high) but should be made while
// no request is in flight.
module object_dictionary_access #(
  parameter int MEM_WORDS   = oda_pkg::MEM_WORDS_DEF,
  parameter int MAP_ENTRIES = oda_pkg::MAP_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  oda_pkg::in_t                  in_req,
  output logic                          out_strobe,
  output oda_pkg::out_t                 out_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [oda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [oda_pkg::MAP_W-1:0]     cfg_data
);

  oda_pkg::job_t       new_job;
  oda_pkg::job_t       head_job;
  oda_pkg::back_stat_t bstat;
  logic                q_nonempty;
  logic                q_full;
  logic                q_pop;
  logic                push;

  assign cfg_ready = 1'b1;
  assign busy      = q_full || bstat.clearing;
  assign push      = start && !busy;

  oda_front #(
    .MEM_WORDS   (MEM_WORDS),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (in_req),
    .job       (new_job)
  );

  oda_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (new_job),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .full     (q_full),
    .head     (head_job)
  );

  oda_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_nonempty),
    .job        (head_job),
    .job_pop    (q_pop),
    .stat       (bstat),
    .res_strobe (out_strobe),
    .res        (out_result)
  );

endmodule

@@ hw/rtl/oda_checker.sv @@
module oda_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input oda_pkg::out_t out_result
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_strobe)
    else $error("request not answered two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_result.status == oda_pkg::ST_RANGE) |->
      (out_result.read_value == 32'd0) && (out_result.word_address == 8'd0))
    else $error("range error result carries data");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("not busy while memory clear starts");

endmodule

bind object_dictionary_access oda_checker u_oda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);
